// ===== hw/rtl/pow2_bucket_allocator_macros.svh =====
// Assertion macros used by the allocator port checker.
`ifndef POW2_BUCKET_ALLOCATOR_MACROS_SVH
`define POW2_BUCKET_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define PBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pba assertion failed");

// Next-cycle implication, sampled on clk, off while reset is low.
`define PBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pba assertion failed");

`endif

// ===== hw/rtl/pba_pkg.sv =====
// Types, constants and size functions of the power-of-two bucket allocator.
`default_nettype none
package pba_pkg;

  localparam int ADDR_W        = 20;
  localparam int BYTES_W       = 21;
  localparam int PS_W          = 5;
  localparam int BKT_W         = 5;
  localparam int CAP_W         = 34;
  localparam int LEFT_W        = 14;
  localparam int MIN_SHIFT     = 3;
  localparam int DEF_PAGE_SHIFT = 12;
  localparam int MIN_PAGE_SHIFT = 6;
  localparam int MAX_PAGE_SHIFT = 16;
  localparam int DEF_HEAP_ADDR_BITS = 20;
  localparam int DEF_NUM_BUCKETS    = 18;
  localparam int DEF_HEADER_BYTES   = 4;
  localparam int DEF_QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_RESIZE = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [BYTES_W-1:0]  request_bytes;
    logic [ADDR_W-1:0]   block_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_address;
    logic [BYTES_W-1:0]  copy_bytes;
    logic [BYTES_W-1:0]  capacity;
    logic                status;
  } out_t;

  // Classified item handed from front to back.
  typedef struct packed {
    mode_t               mode;
    logic [BYTES_W-1:0]  request_bytes;
    logic [ADDR_W-1:0]   block_address;
    logic [BKT_W-1:0]    bucket;
    logic                fit;
  } q_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HREAD,
    ST_GRAB,
    ST_CARVE,
    ST_POP,
    ST_FREEOLD
  } bst_t;

  function automatic logic [PS_W-1:0] eff_shift_f(input logic [PS_W-1:0] ps);
    logic [PS_W-1:0] r;
    if (ps < PS_W'(MIN_PAGE_SHIFT)) r = PS_W'(MIN_PAGE_SHIFT);
    else if (ps > PS_W'(MAX_PAGE_SHIFT)) r = PS_W'(MAX_PAGE_SHIFT);
    else r = ps;
    return r;
  endfunction

  function automatic logic [CAP_W-1:0] size_f(input logic [BKT_W-1:0] b);
    return CAP_W'(1) << (6'(b) + 6'(MIN_SHIFT));
  endfunction

  // Usable bytes of bucket b under page shift es.
  function automatic logic [CAP_W-1:0] usable_f(input logic [BKT_W-1:0] b,
                                                input logic [PS_W-1:0] es,
                                                input logic [3:0] hdr);
    logic [CAP_W-1:0] sz;
    logic [CAP_W-1:0] pg;
    logic [CAP_W-1:0] r;
    sz = size_f(b);
    pg = CAP_W'(1) << es;
    if (sz < pg) r = sz - CAP_W'(hdr);
    else r = sz + pg - CAP_W'(hdr);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pba_front.sv =====
// Front end: accept items and find the bucket each request needs.
`default_nettype none
module pba_front #(
  parameter int NUM_BUCKETS  = 18,
  parameter int HEADER_BYTES = 4
) (
  input  wire logic                   start,
  input  wire logic                   busy,
  input  wire pba_pkg::in_t           in_data,
  input  wire logic [pba_pkg::PS_W-1:0] es,
  output logic                        push,
  output pba_pkg::q_t                 entry
);
  import pba_pkg::*;

  logic [BKT_W-1:0] bkt;
  logic             fit;

  // Smallest bucket whose usable size covers the request.
  always_comb begin
    bkt = '0;
    fit = 1'b0;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (CAP_W'(in_data.request_bytes) <= usable_f(BKT_W'(i), es, 4'(HEADER_BYTES))) begin
        bkt = BKT_W'(i);
        fit = 1'b1;
      end
    end
  end

  assign push                = start && !busy;
  assign entry.mode          = in_data.mode;
  assign entry.request_bytes = in_data.request_bytes;
  assign entry.block_address = in_data.block_address;
  assign entry.bucket        = bkt;
  assign entry.fit           = fit;

endmodule
`default_nettype wire

// ===== hw/rtl/pba_queue.sv =====
// Short queue of classified items between front and back.
`default_nettype none
module pba_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire pba_pkg::q_t wdata,
  input  wire logic        pop,
  output pba_pkg::q_t      rdata,
  output logic             empty,
  output logic             full
);
  import pba_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  q_t            slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign rdata = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= wdata;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pba_back.sv =====
// Back end: free lists, break pointer, header memory and the op sequencer.
`default_nettype none
module pba_back #(
  parameter int HEAP_ADDR_BITS = 20,
  parameter int NUM_BUCKETS    = 18,
  parameter int HEADER_BYTES   = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [pba_pkg::PS_W-1:0] es,
  input  wire logic                     cfg_we,
  input  wire logic [pba_pkg::PS_W-1:0] cfg_es,
  input  wire pba_pkg::q_t              q_data,
  input  wire logic                     q_empty,
  output logic                          q_pop,
  output logic                          out_valid,
  output pba_pkg::out_t                 out_data
);
  import pba_pkg::*;

  localparam int HAB   = HEAP_ADDR_BITS;
  localparam int BRK_W = HAB + 1;
  localparam int WORDS = 1 << (HAB - 2);
  localparam int FH_IW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int EW    = CAP_W + 1;

  // Header memory: one word per four heap bytes.
  logic [HAB-1:0] mem [WORDS];
  logic [HAB-1:0] rdata_r;
  logic [HAB-3:0] raddr, waddr;
  logic [HAB-1:0] wdata;
  logic           we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  bst_t               state_r, state_nxt;
  q_t                 ent_r, ent_nxt;
  logic [BKT_W-1:0]   idx_r, idx_nxt;
  logic               hval_r, hval_nxt;
  logic [HAB-1:0]     h_r, h_nxt;
  logic [CAP_W-1:0]   onb_r, onb_nxt;
  logic [HAB-1:0]     op_r, op_nxt;
  logic [HAB-1:0]     base_r, base_nxt;
  logic [HAB-1:0]     addr_r, addr_nxt;
  logic [LEFT_W-1:0]  left_r, left_nxt;
  logic [BRK_W-1:0]   brk_r, brk_nxt;
  logic [HAB-1:0]     fh_r [NUM_BUCKETS];
  logic [ADDR_W-1:0]  res_r, res_nxt;
  logic [BYTES_W-1:0] copy_r, copy_nxt;
  logic [BYTES_W-1:0] cap_r, cap_nxt;
  logic               stat_r, stat_nxt;
  logic               ov_r, ov_nxt;

  logic [FH_IW-1:0]   fh_sel;
  logic [HAB-1:0]     fh_rd;
  logic               fh_we;
  logic [HAB-1:0]     fh_wd;

  logic [BKT_W-1:0]   hidx;
  logic               hval;
  logic [CAP_W-1:0]   onb, low, sz, pg, amt;
  logic [CAP_W-1:0]   nb;
  logic               keep;
  logic [EW-1:0]      end_v;
  logic [5:0]         nsh;

  assign fh_rd = fh_r[fh_sel];
  assign nb    = CAP_W'(ent_r.request_bytes);
  assign hidx  = rdata_r[BKT_W-1:0];
  assign hval  = (ent_r.block_address != '0) && (rdata_r < HAB'(NUM_BUCKETS));
  assign onb   = hval ? usable_f(hidx, es, 4'(HEADER_BYTES)) : '0;
  assign low   = (hval && hidx != '0) ? usable_f(hidx - 1'b1, es, 4'(HEADER_BYTES)) : '0;
  assign keep  = hval && (nb <= onb) && (nb > low);
  assign sz    = size_f(ent_r.bucket);
  assign pg    = CAP_W'(1) << es;
  assign amt   = (sz < pg) ? pg : sz + pg;
  assign end_v = EW'(brk_r) + EW'(amt);
  assign nsh   = 6'(es) - 6'(ent_r.bucket) - 6'(MIN_SHIFT);

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    idx_nxt   = idx_r;
    hval_nxt  = hval_r;
    h_nxt     = h_r;
    onb_nxt   = onb_r;
    op_nxt    = op_r;
    base_nxt  = base_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    brk_nxt   = brk_r;
    res_nxt   = res_r;
    copy_nxt  = copy_r;
    cap_nxt   = cap_r;
    stat_nxt  = stat_r;
    ov_nxt    = 1'b0;
    q_pop     = 1'b0;
    raddr     = h_r[HAB-1:2];
    we        = 1'b0;
    waddr     = h_r[HAB-1:2];
    wdata     = '0;
    fh_sel    = ent_r.bucket[FH_IW-1:0];
    fh_we     = 1'b0;
    fh_wd     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ent_nxt   = q_data;
          h_nxt     = HAB'(q_data.block_address) - HAB'(HEADER_BYTES);
          raddr     = h_nxt[HAB-1:2];
          state_nxt = ST_HREAD;
        end
      end
      ST_HREAD: begin
        idx_nxt  = hidx;
        hval_nxt = hval;
        onb_nxt  = onb;
        res_nxt  = '0;
        copy_nxt = '0;
        cap_nxt  = '0;
        stat_nxt = 1'b0;
        fh_sel   = hidx[FH_IW-1:0];
        unique case (ent_r.mode)
          MODE_FREE: begin
            if (hval) begin
              we    = 1'b1;
              wdata = fh_rd;
              fh_we = 1'b1;
              fh_wd = h_r;
            end
            ov_nxt    = 1'b1;
            state_nxt = ST_IDLE;
          end
          MODE_QUERY: begin
            cap_nxt   = BYTES_W'(onb);
            ov_nxt    = 1'b1;
            state_nxt = ST_IDLE;
          end
          MODE_ALLOC, MODE_RESIZE: begin
            if (ent_r.mode == MODE_RESIZE && keep) begin
              res_nxt   = ent_r.block_address;
              cap_nxt   = BYTES_W'(onb);
              ov_nxt    = 1'b1;
              state_nxt = ST_IDLE;
            end else if (!ent_r.fit) begin
              stat_nxt  = 1'b1;
              ov_nxt    = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_GRAB;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_GRAB: begin
        if (fh_rd != '0) begin
          raddr     = fh_rd[HAB-1:2];
          op_nxt    = fh_rd;
          state_nxt = ST_POP;
        end else if (end_v > (EW'(1) << HAB)) begin
          // Heap exhausted: fail, old block stays.
          stat_nxt  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          base_nxt  = brk_r[HAB-1:0];
          addr_nxt  = brk_r[HAB-1:0];
          left_nxt  = (sz < pg) ? LEFT_W'((CAP_W'(1) << nsh) - 1'b1) : '0;
          brk_nxt   = BRK_W'(end_v);
          state_nxt = ST_CARVE;
        end
      end
      ST_CARVE: begin
        // Link one fresh block per cycle.
        we       = 1'b1;
        waddr    = addr_r[HAB-1:2];
        wdata    = (left_r != '0) ? addr_r + HAB'(sz) : '0;
        addr_nxt = addr_r + HAB'(sz);
        left_nxt = left_r - 1'b1;
        if (left_r == '0) begin
          fh_we     = 1'b1;
          fh_wd     = base_r;
          state_nxt = ST_GRAB;
        end
      end
      ST_POP: begin
        fh_we    = 1'b1;
        fh_wd    = rdata_r;
        we       = 1'b1;
        waddr    = op_r[HAB-1:2];
        wdata    = HAB'(ent_r.bucket);
        res_nxt  = ADDR_W'(op_r + HAB'(HEADER_BYTES));
        cap_nxt  = BYTES_W'(usable_f(ent_r.bucket, es, 4'(HEADER_BYTES)));
        stat_nxt = 1'b0;
        if (ent_r.mode == MODE_RESIZE && hval_r) begin
          copy_nxt  = BYTES_W'((nb < onb_r) ? nb : onb_r);
          state_nxt = ST_FREEOLD;
        end else begin
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FREEOLD: begin
        fh_sel    = idx_r[FH_IW-1:0];
        we        = 1'b1;
        wdata     = fh_rd;
        fh_we     = 1'b1;
        fh_wd     = h_r;
        ov_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_we) begin
      brk_nxt = (BRK_W'(1) << cfg_es) - BRK_W'(HEADER_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      brk_r   <= (BRK_W'(1) << DEF_PAGE_SHIFT) - BRK_W'(HEADER_BYTES);
      for (int i = 0; i < NUM_BUCKETS; i++) fh_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      brk_r   <= brk_nxt;
      if (fh_we) fh_r[fh_sel] <= fh_wd;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    idx_r  <= idx_nxt;
    hval_r <= hval_nxt;
    h_r    <= h_nxt;
    onb_r  <= onb_nxt;
    op_r   <= op_nxt;
    base_r <= base_nxt;
    addr_r <= addr_nxt;
    left_r <= left_nxt;
    res_r  <= res_nxt;
    copy_r <= copy_nxt;
    cap_r  <= cap_nxt;
    stat_r <= stat_nxt;
  end

  assign out_valid               = ov_r;
  assign out_data.result_address = res_r;
  assign out_data.copy_bytes     = copy_r;
  assign out_data.capacity       = cap_r;
  assign out_data.status         = stat_r;

endmodule
`default_nettype wire

// ===== hw/rtl/pow2_bucket_allocator.sv =====
// Top level of the power-of-two bucket allocator.
// The back end handles one item at a time, from header read to result; a refill
//   carves up to page / 8 blocks, one header write each.
// Up to two items queue while the back end works, and the receiver cannot stall;
//   each result shows for one cycle on out_valid.
// Reset (rst_n low, synchronous): free lists empty, page shift 12, break at 4092.
`default_nettype none
module pow2_bucket_allocator #(
  parameter int HEAP_ADDR_BITS = pba_pkg::DEF_HEAP_ADDR_BITS,
  parameter int NUM_BUCKETS    = pba_pkg::DEF_NUM_BUCKETS,
  parameter int HEADER_BYTES   = pba_pkg::DEF_HEADER_BYTES
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire pba_pkg::in_t             in_data,
  output logic                          out_valid,
  output pba_pkg::out_t                 out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [pba_pkg::PS_W-1:0] cfg_data
);
  import pba_pkg::*;

  // Page shift register; the clamped value drives all size math.
  logic [PS_W-1:0] ps_r, ps_nxt;
  logic [PS_W-1:0] es;
  logic            cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign es        = eff_shift_f(ps_r);
  assign ps_nxt    = cfg_we ? cfg_data : ps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= PS_W'(DEF_PAGE_SHIFT);
    end else begin
      ps_r <= ps_nxt;
    end
  end

  logic q_push, q_pop, q_empty, q_full;
  q_t   q_wdata, q_rdata;

  // Hold off new items only while the queue is full.
  assign busy = q_full;

  pba_front #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .start  (start),
    .busy   (busy),
    .in_data(in_data),
    .es     (es),
    .push   (q_push),
    .entry  (q_wdata)
  );

  pba_queue #(
    .DEPTH(DEF_QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty),
    .full (q_full)
  );

  // Back end reloads the break pointer on every page shift write.
  pba_back #(
    .HEAP_ADDR_BITS(HEAP_ADDR_BITS),
    .NUM_BUCKETS   (NUM_BUCKETS),
    .HEADER_BYTES  (HEADER_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .es       (es),
    .cfg_we   (cfg_we),
    .cfg_es   (eff_shift_f(cfg_data)),
    .q_data   (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/pba_checker.sv =====
// Port-level assertions for the allocator and their bind.
`default_nettype none
`include "pow2_bucket_allocator_macros.svh"
module pba_port_sva (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire pba_pkg::out_t out_data
);
  import pba_pkg::*;

  logic fields_zero;

  assign fields_zero = (out_data.result_address == '0) && (out_data.copy_bytes == '0) &&
                       (out_data.capacity == '0);

  `PBA_ASSERT_NEXT(a_strobe_gap, out_valid, !out_valid)
  `PBA_ASSERT_IMP(a_fail_zero, out_valid && out_data.status, fields_zero)
  `PBA_ASSERT_IMP(a_copy_ok, out_valid && out_data.copy_bytes != '0, !out_data.status && out_data.capacity != '0)

endmodule

bind pow2_bucket_allocator pba_port_sva u_pba_port_sva (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_data (out_data)
);
`default_nettype wire
